// File: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers shared by the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLY(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle implication violated");

// next-cycle implication
`define ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication violated");

`endif

// File: hw/rtl/sitg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sitg_pkg
// Shared widths, register codes and request/table types.
// ----------------------------------------------------------------------------
package sitg_pkg;

    localparam int IDX_W       = 9;
    // table size is a power of two, so the split per point is a shift
    localparam int POINTS      = 1 << IDX_W;
    localparam int IDX_CMP_W   = 13;
    localparam int SPACING_W   = 16;
    localparam int VEL_W       = 16;
    localparam int RANGE_W     = 20;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 20;
    localparam int REM_W       = 12;
    localparam int A_W         = 21;
    localparam int RECIP_W     = 22;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    localparam logic [SPACING_W-1:0] SPACING_MAX    = 16'hFFFF;
    localparam logic [VEL_W-1:0]     VELOCITY_RESET = 16'd1480;
    localparam logic [RANGE_W-1:0]   RANGE_RESET    = 20'd0;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SOUND_VELOCITY = 2'd0,
        REG_RANGE_LENGTH   = 2'd1
    } cfg_reg_t;

    typedef struct packed {
        logic [SPACING_W-1:0] base;
        logic [REM_W-1:0]     rem;
    } tbl_t;

    typedef struct packed {
        logic [A_W-1:0]   prod;
        logic [IDX_W-1:0] idx;
        logic             in_table;
        logic             has_prev;
        logic             is_final;
    } entry_t;

endpackage

// File: hw/rtl/sitg_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sitg_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module sitg_div #(
    parameter int NUM_W = 34,
    parameter int DEN_W = 16
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [NUM_W-1:0] dividend,
    input  logic [DEN_W-1:0] divisor,
    output logic             done,
    output logic [NUM_W-1:0] quotient
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [NUM_W-1:0] quo_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [DEN_W-1:0] den_reg;
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             fits;

    assign trial = {rem_reg, quo_reg[NUM_W-1]};
    assign diff  = trial - {1'b0, den_reg};
    assign fits  = trial >= {1'b0, den_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(NUM_W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= dividend;
            rem_reg <= '0;
            den_reg <= divisor;
        end else if (busy_reg) begin
            quo_reg <= {quo_reg[NUM_W-2:0], fits};
            rem_reg <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// File: hw/rtl/sitg_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sitg_front
// Accepts requests, classifies the index and forms (index-1)*rem.
// ----------------------------------------------------------------------------
module sitg_front (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        enable,
    input  sitg_pkg::tbl_t              tbl,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [sitg_pkg::IDX_W-1:0]  s_entry_index,
    output logic                        push_valid,
    input  logic                        push_ready,
    output sitg_pkg::entry_t            push_entry
);

    import sitg_pkg::*;

    localparam logic [IDX_CMP_W-1:0] LAST_IDX = IDX_CMP_W'(POINTS - 1);

    logic             valid_reg;
    entry_t           entry_reg;
    entry_t           entry_next;
    logic             accept;
    logic [IDX_W-1:0] idx_prev;

    assign s_ready  = enable && (!valid_reg || push_ready);
    assign accept   = s_valid && s_ready;
    assign idx_prev = s_entry_index - IDX_W'(1);

    always_comb begin
        entry_next.prod     = A_W'(idx_prev) * A_W'(tbl.rem);
        entry_next.idx      = s_entry_index;
        entry_next.in_table = IDX_CMP_W'(s_entry_index) <= LAST_IDX;
        entry_next.has_prev = s_entry_index != '0;
        entry_next.is_final = IDX_CMP_W'(s_entry_index) == LAST_IDX;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (accept) begin
            valid_reg <= 1'b1;
        end else if (push_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            entry_reg <= entry_next;
        end
    end

    assign push_valid = valid_reg;
    assign push_entry = entry_reg;

endmodule

// File: hw/rtl/sitg_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sitg_queue
// Short FIFO between the front and back halves.
// ----------------------------------------------------------------------------
module sitg_queue (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push_valid,
    output logic             push_ready,
    input  sitg_pkg::entry_t push_entry,
    output logic             pop_valid,
    input  logic             pop_ready,
    output sitg_pkg::entry_t pop_entry
);

    import sitg_pkg::*;

    entry_t              slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QCNT_W-1:0]   count_reg;
    logic                do_push;
    logic                do_pop;

    assign push_ready = count_reg != QCNT_W'(QUEUE_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_entry  = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + QCNT_W'(1);
            end else if (!do_push && do_pop) begin
                count_reg <= count_reg - QCNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

// File: hw/rtl/sitg_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sitg_back
// Remainder step test by reciprocal multiply, spacing and output register.
// ----------------------------------------------------------------------------
module sitg_back (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  sitg_pkg::tbl_t                  tbl,
    input  logic                            pop_valid,
    output logic                            pop_ready,
    input  sitg_pkg::entry_t                pop_entry,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [sitg_pkg::SPACING_W-1:0]  m_spacing,
    output logic [sitg_pkg::IDX_W-1:0]      m_point_index,
    output logic                            m_is_final
);

    import sitg_pkg::*;

    localparam int                 DIVISOR = POINTS - 1;
    localparam logic [RECIP_W-1:0] RECIP   = RECIP_W'((64'd1 << A_W) / DIVISOR);
    localparam logic [A_W-1:0]     DIV_A   = A_W'(DIVISOR);
    localparam logic [A_W:0]       DIV_SUM = (A_W + 1)'(DIVISOR);
    localparam int                 PROD_W  = A_W + RECIP_W;

    logic                 s1_valid_reg;
    entry_t               s1_entry_reg;
    logic [A_W-1:0]       s1_quot_reg;
    logic                 s2_valid_reg;
    entry_t               s2_entry_reg;
    logic [A_W-1:0]       s2_resid_reg;
    logic                 out_valid_reg;
    logic [SPACING_W-1:0] spacing_reg;
    logic [IDX_W-1:0]     idx_reg;
    logic                 final_reg;

    logic                 s1_ready;
    logic                 s2_ready;
    logic                 out_ready;
    logic [PROD_W-1:0]    recip_prod;
    logic [A_W-1:0]       back_prod;
    logic [A_W-1:0]       resid_fix;
    logic                 step;
    logic [SPACING_W-1:0] spacing_next;

    assign out_ready = !out_valid_reg || m_ready;
    assign s2_ready  = !s2_valid_reg || out_ready;
    assign s1_ready  = !s1_valid_reg || s2_ready;
    assign pop_ready = s1_ready;

    assign recip_prod = PROD_W'(pop_entry.prod) * PROD_W'(RECIP);
    assign back_prod  = A_W'(s1_quot_reg * DIV_A);
    assign resid_fix  = (s2_resid_reg >= DIV_A) ? s2_resid_reg - DIV_A : s2_resid_reg;
    assign step       = s2_entry_reg.has_prev && s2_entry_reg.in_table &&
                        ((A_W + 1)'(resid_fix) + (A_W + 1)'(tbl.rem) >= DIV_SUM);

    always_comb begin
        if (!s2_entry_reg.in_table) begin
            spacing_next = '0;
        end else if (tbl.base == SPACING_MAX) begin
            spacing_next = SPACING_MAX;
        end else begin
            spacing_next = tbl.base + SPACING_W'(step);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s1_ready) begin
                s1_valid_reg <= pop_valid;
            end
            if (s2_ready) begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (out_ready) begin
                out_valid_reg <= s2_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_ready && pop_valid) begin
            s1_entry_reg <= pop_entry;
            s1_quot_reg  <= recip_prod[A_W +: A_W];
        end
        if (s2_ready && s1_valid_reg) begin
            s2_entry_reg <= s1_entry_reg;
            s2_resid_reg <= s1_entry_reg.prod - back_prod;
        end
        if (out_ready && s2_valid_reg) begin
            spacing_reg <= spacing_next;
            idx_reg     <= s2_entry_reg.idx;
            final_reg   <= s2_entry_reg.is_final;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_spacing     = spacing_reg;
    assign m_point_index = idx_reg;
    assign m_is_final    = final_reg;

endmodule

// File: hw/rtl/sample_interval_table_generator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sample_interval_table_generator
// Decimation spacing per display point of an A-scan, remainder distributed
// Bresenham style over the points.
//
// Usage: write sound_velocity (index 0) and range_length (index 1) on the
// cfg channel while no request is in flight. Each write, and reset, starts
// a table recompute: total = range * SAMPLE_RATE_MHZ * 125 / velocity on a
// bit-serial divider; the split over the 512 points is a shift and a mask.
// s_ready stays low until it is done. After reset the recompute runs on
// the reset values. Requests on s_ carry an entry index; each yields
// exactly one result on m_ with the spacing, the index and a last-point
// flag. One request per cycle is sustained while m_ready stays high;
// m_valid follows through the front register, the queue and three back
// stages (reciprocal multiply, residue, output register). When m_ready
// is low the back stages and the four-entry queue fill, then s_ready
// drops; nothing is lost.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sample_interval_table_generator #(
    parameter int SAMPLE_RATE_MHZ = 100,
    parameter int MIN_TOTAL       = 512
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [sitg_pkg::IDX_W-1:0]       s_entry_index,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [sitg_pkg::SPACING_W-1:0]   m_spacing,
    output logic [sitg_pkg::IDX_W-1:0]       m_point_index,
    output logic                             m_is_final,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [sitg_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [sitg_pkg::CFG_DATA_W-1:0]  cfg_data
);

    import sitg_pkg::*;

    localparam int SCALE   = SAMPLE_RATE_MHZ * 125;
    localparam int SCALE_W = $clog2(SCALE + 1);
    localparam int NUM_W   = RANGE_W + SCALE_W;
    localparam int QUO_W   = NUM_W - IDX_W;
    localparam logic [IDX_CMP_W-1:0] LAST_IDX = IDX_CMP_W'(POINTS - 1);

    typedef enum logic [1:0] {
        ST_TOTAL_START,
        ST_TOTAL_WAIT,
        ST_READY
    } state_t;

    state_t               state_reg;
    logic [VEL_W-1:0]     velocity_reg;
    logic [RANGE_W-1:0]   range_reg;
    tbl_t                 tbl_reg;

    logic [VEL_W-1:0]     vel_eff;
    logic [NUM_W-1:0]     scaled;
    logic                 div_start;
    logic                 div_done;
    logic [NUM_W-1:0]     div_quo;
    logic [QUO_W-1:0]     per_point;
    logic [QUO_W-1:0]     base_wide;
    logic [SPACING_W-1:0] base_sat;
    logic                 total_short;
    logic                 m_beyond;
    logic                 m_last;

    logic                 push_valid;
    logic                 push_ready;
    entry_t               push_entry;
    logic                 pop_valid;
    logic                 pop_ready;
    entry_t               pop_entry;

    assign cfg_ready = 1'b1;

    assign vel_eff     = (velocity_reg == '0) ? VEL_W'(1) : velocity_reg;
    assign scaled      = NUM_W'(range_reg) * NUM_W'(SCALE);
    assign div_start   = state_reg == ST_TOTAL_START;
    assign per_point   = div_quo[NUM_W-1:IDX_W];
    assign base_wide   = (per_point == '0) ? '0 : per_point - QUO_W'(1);
    assign base_sat    = (|base_wide[QUO_W-1:SPACING_W]) ? SPACING_MAX
                                                         : base_wide[SPACING_W-1:0];
    assign total_short = 64'(div_quo) < 64'(MIN_TOTAL);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_TOTAL_START;
            velocity_reg <= VELOCITY_RESET;
            range_reg    <= RANGE_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_SOUND_VELOCITY: begin
                    velocity_reg <= cfg_data[VEL_W-1:0];
                end
                REG_RANGE_LENGTH: begin
                    range_reg <= cfg_data[RANGE_W-1:0];
                end
                default: begin
                end
            endcase
            state_reg <= ST_TOTAL_START;
        end else begin
            case (state_reg)
                ST_TOTAL_START: begin
                    state_reg <= ST_TOTAL_WAIT;
                end
                ST_TOTAL_WAIT: begin
                    if (div_done) begin
                        tbl_reg.base <= total_short ? '0 : base_sat;
                        tbl_reg.rem  <= total_short ? '0 : REM_W'(div_quo[IDX_W-1:0]);
                        state_reg    <= ST_READY;
                    end
                end
                ST_READY: begin
                end
                default: begin
                    state_reg <= ST_TOTAL_START;
                end
            endcase
        end
    end

    sitg_div #(
        .NUM_W (NUM_W),
        .DEN_W (VEL_W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (scaled),
        .divisor  (vel_eff),
        .done     (div_done),
        .quotient (div_quo)
    );

    sitg_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .enable        (state_reg == ST_READY),
        .tbl           (tbl_reg),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_entry_index (s_entry_index),
        .push_valid    (push_valid),
        .push_ready    (push_ready),
        .push_entry    (push_entry)
    );

    sitg_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_entry  (pop_entry)
    );

    sitg_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .tbl           (tbl_reg),
        .pop_valid     (pop_valid),
        .pop_ready     (pop_ready),
        .pop_entry     (pop_entry),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_spacing     (m_spacing),
        .m_point_index (m_point_index),
        .m_is_final    (m_is_final)
    );

    assign m_beyond = IDX_CMP_W'(m_point_index) > LAST_IDX;
    assign m_last   = IDX_CMP_W'(m_point_index) == LAST_IDX;

    `ASSERT_NEXT(a_cfg_blocks_requests, aclk, aresetn, cfg_valid && cfg_ready, !s_ready)
    `ASSERT_IMPLY(a_beyond_table_zero, aclk, aresetn, m_valid && m_beyond, m_spacing == '0)
    `ASSERT_IMPLY(a_final_flag, aclk, aresetn, m_valid, m_is_final == m_last)

endmodule

// File: test/sample_interval_table_generator_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sample_interval_table_generator_test
// Checks the per-point decimation spacing against a local integer
// calculation of the sample total and its remainder spread over the points.
// Directed register settings cover the extremes, including zero velocity,
// short range and saturated spacing. Random settings then follow, with
// index sweeps and scattered lookups, random stalls on both channels, one
// long receiver hold-off, and a clean tail with no stalls.
// ----------------------------------------------------------------------------
module sample_interval_table_generator_test;
    import sitg_pkg::*;

    localparam int SAMPLE_RATE_MHZ = 100;
    localparam int MIN_TOTAL       = 512;
    localparam int ENTRY_COUNT     = 1050;
    localparam int TAIL_COUNT      = 100;
    localparam int HOLD_CYCLES     = 120;
    localparam int WATCHDOG_LIMIT  = 3000;

    typedef enum logic [1:0] {
        REQ_ENTRY,
        REQ_WRITE,
        REQ_SETTLE
    } req_kind_t;

    typedef struct {
        req_kind_t             kind;
        cfg_reg_t              cfg_sel;
        logic [CFG_DATA_W-1:0] value;
        logic                  quiet;
        logic                  hold;
    } pending_req_t;

    typedef struct {
        logic [SPACING_W-1:0] spacing;
        logic [IDX_W-1:0]     point_index;
        logic                 is_final;
    } spacing_result_t;

    logic                  aclk          = 1'b0;
    logic                  aresetn       = 1'b0;
    logic                  s_valid       = 1'b0;
    logic                  s_ready;
    logic [IDX_W-1:0]      s_entry_index = '0;
    logic                  m_valid;
    logic                  m_ready       = 1'b0;
    logic [SPACING_W-1:0]  m_spacing;
    logic [IDX_W-1:0]      m_point_index;
    logic                  m_is_final;
    logic                  cfg_valid     = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index     = '0;
    logic [CFG_DATA_W-1:0] cfg_data      = '0;

    pending_req_t    pending[$];
    spacing_result_t spacing_expect[$];

    logic [VEL_W-1:0]   model_velocity = VELOCITY_RESET;
    logic [RANGE_W-1:0] model_range    = RANGE_RESET;

    int  errors        = 0;
    int  entries_sent  = 0;
    int  results_seen  = 0;
    int  settings_used = 1;
    int  zero_seen     = 0;
    int  sat_seen      = 0;
    int  tx_gap        = 0;
    int  rx_gap        = 0;
    int  hold_left     = 0;
    int  idle_cycles   = 0;
    logic hold_req     = 1'b0;
    logic hold_done    = 1'b0;
    logic nxt_s_valid;
    logic nxt_cfg_valid;
    logic nxt_m_ready;
    logic rx_quiet;
    spacing_result_t want;
    spacing_result_t rx_want;

    sample_interval_table_generator uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_entry_index (s_entry_index),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_spacing     (m_spacing),
        .m_point_index (m_point_index),
        .m_is_final    (m_is_final),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #10 aclk = ~aclk;

    function automatic spacing_result_t predict_spacing(input logic [IDX_W-1:0] idx);
        spacing_result_t  r;
        longint unsigned  divisor;
        longint unsigned  total;
        longint unsigned  quot;
        longint unsigned  rest;
        longint unsigned  ix;
        longint unsigned  s;
        ix            = idx;
        r.point_index = idx;
        r.is_final    = (ix == POINTS - 1);
        s             = 0;
        divisor       = (model_velocity == '0) ? 64'd1 : 64'(model_velocity);
        total         = (64'(model_range) * SAMPLE_RATE_MHZ * 125) / divisor;
        if (ix < POINTS && total >= MIN_TOTAL) begin
            quot = total / POINTS;
            rest = total % POINTS;
            s    = ((quot < 1) ? 64'd1 : quot) - 1;
            if (ix >= 1 && (ix * rest) / (POINTS - 1) > ((ix - 1) * rest) / (POINTS - 1))
                s = s + 1;
            if (s > 64'(SPACING_MAX))
                s = 64'(SPACING_MAX);
        end
        r.spacing = s[SPACING_W-1:0];
        return r;
    endfunction

    function automatic void add_entry(input int idx, input logic quiet, input logic hold);
        pending_req_t p;
        p.kind    = REQ_ENTRY;
        p.cfg_sel = REG_SOUND_VELOCITY;
        p.value   = CFG_DATA_W'(idx);
        p.quiet   = quiet;
        p.hold    = hold;
        pending.push_back(p);
    endfunction

    function automatic void add_settle();
        pending_req_t p;
        p.kind    = REQ_SETTLE;
        p.cfg_sel = REG_SOUND_VELOCITY;
        p.value   = '0;
        p.quiet   = 1'b0;
        p.hold    = 1'b0;
        pending.push_back(p);
    endfunction

    // registers change only once the pipe is empty
    function automatic void add_setting(input int vel, input int rng, input int which);
        pending_req_t p;
        add_settle();
        p.kind  = REQ_WRITE;
        p.quiet = 1'b0;
        p.hold  = 1'b0;
        if (which != 1) begin
            p.cfg_sel = REG_SOUND_VELOCITY;
            p.value   = CFG_DATA_W'(vel);
            pending.push_back(p);
        end
        if (which != 0) begin
            p.cfg_sel = REG_RANGE_LENGTH;
            p.value   = CFG_DATA_W'(rng);
            pending.push_back(p);
        end
        settings_used++;
    endfunction

    function automatic void add_random_setting();
        int vel;
        int rng;
        if ($urandom_range(0, 9) < 7)
            vel = $urandom_range(300, 6500);
        else
            vel = $urandom_range(0, 65535);
        vel = vel | (($urandom_range(0, 15)) << 16);
        rng = $urandom_range(0, (1 << RANGE_W) - 1) >> $urandom_range(0, 14);
        add_setting(vel, rng, $urandom_range(0, 3));
    endfunction

    // streaming sweeps, as a table refill does, mixed about evenly with scattered lookups
    function automatic void add_random_entries(input int count, input logic quiet,
                                               input int hold_at);
        int pos;
        int k;
        pos = $urandom_range(0, POINTS - 1);
        for (k = 0; k < count; k++) begin
            if ($urandom_range(0, 1) == 0) begin
                pos = (pos + 1) % POINTS;
            end else begin
                pos = $urandom_range(0, POINTS - 1);
            end
            add_entry(pos, quiet, k == hold_at);
        end
    endfunction

    // sender
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid   <= 1'b0;
            cfg_valid <= 1'b0;
        end else begin
            nxt_s_valid   = s_valid;
            nxt_cfg_valid = cfg_valid;
            if (s_valid && s_ready) begin
                want = predict_spacing(s_entry_index);
                spacing_expect.push_back(want);
                entries_sent++;
                if (want.spacing == '0)
                    zero_seen++;
                if (want.spacing == SPACING_MAX)
                    sat_seen++;
                nxt_s_valid = 1'b0;
            end
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == REG_SOUND_VELOCITY)
                    model_velocity = cfg_data[VEL_W-1:0];
                else if (cfg_index == REG_RANGE_LENGTH)
                    model_range = cfg_data[RANGE_W-1:0];
                nxt_cfg_valid = 1'b0;
            end
            if (!nxt_s_valid && !nxt_cfg_valid) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                end else if (pending.size() > 0) begin
                    case (pending[0].kind)
                        REQ_ENTRY: begin
                            if (!pending[0].quiet && $urandom_range(0, 5) == 0) begin
                                tx_gap = $urandom_range(1, 15) - 1;
                            end else begin
                                nxt_s_valid = 1'b1;
                                s_entry_index <= pending[0].value[IDX_W-1:0];
                                if (pending[0].hold)
                                    hold_req <= 1'b1;
                                void'(pending.pop_front());
                            end
                        end
                        REQ_WRITE: begin
                            nxt_cfg_valid = 1'b1;
                            cfg_index <= pending[0].cfg_sel;
                            cfg_data  <= pending[0].value;
                            void'(pending.pop_front());
                        end
                        REQ_SETTLE: begin
                            if (spacing_expect.size() == 0)
                                void'(pending.pop_front());
                        end
                        default: void'(pending.pop_front());
                    endcase
                end
            end
            s_valid   <= nxt_s_valid;
            cfg_valid <= nxt_cfg_valid;
        end
    end

    // receiver and checker
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                results_seen++;
                if (spacing_expect.size() == 0) begin
                    errors++;
                    $display("%0t: result with no request pending, spacing %0d index %0d",
                             $time, m_spacing, m_point_index);
                end else begin
                    rx_want = spacing_expect.pop_front();
                    if (m_spacing !== rx_want.spacing) begin
                        errors++;
                        $display("%0t: spacing mismatch, expected %0d, actual %0d",
                                 $time, rx_want.spacing, m_spacing);
                    end
                    if (m_point_index !== rx_want.point_index) begin
                        errors++;
                        $display("%0t: point_index mismatch, expected %0d, actual %0d",
                                 $time, rx_want.point_index, m_point_index);
                    end
                    if (m_is_final !== rx_want.is_final) begin
                        errors++;
                        $display("%0t: is_final mismatch, expected %0b, actual %0b",
                                 $time, rx_want.is_final, m_is_final);
                    end
                end
            end
            rx_quiet = (results_seen >= ENTRY_COUNT - TAIL_COUNT) ||
                       (results_seen >= 600 && results_seen < 680);
            if (hold_left > 0) begin
                hold_left--;
                nxt_m_ready = 1'b0;
            end else if (hold_req && !hold_done) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES - 1;
                nxt_m_ready = 1'b0;
            end else if (rx_gap > 0) begin
                rx_gap--;
                nxt_m_ready = 1'b0;
            end else if (!rx_quiet && $urandom_range(0, 5) == 0) begin
                rx_gap = $urandom_range(1, 15) - 1;
                nxt_m_ready = 1'b0;
            end else begin
                nxt_m_ready = 1'b1;
            end
            m_ready <= nxt_m_ready;
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no progress for %0d cycles, %0d requests still queued",
                     $time, WATCHDOG_LIMIT, spacing_expect.size());
            $display("sample_interval_table_generator verification failed");
            $finish;
        end
    end

    initial begin
        int remaining;
        int chunk;

        // reset values: zero range, short total
        add_entry(0, 1'b0, 1'b0);
        add_entry(511, 1'b0, 1'b0);
        add_entry(1, 1'b0, 1'b0);
        // typical water scan, 1000 mm
        add_setting(1480, 16000, 2);
        add_entry(0, 1'b0, 1'b0);
        add_entry(1, 1'b0, 1'b0);
        add_entry(255, 1'b0, 1'b0);
        add_entry(256, 1'b0, 1'b0);
        add_entry(510, 1'b0, 1'b0);
        add_entry(511, 1'b0, 1'b0);
        // zero velocity taken as one, spacing saturates
        add_setting(0, (1 << RANGE_W) - 1, 2);
        add_entry(0, 1'b0, 1'b0);
        add_entry(511, 1'b0, 1'b0);
        add_entry(300, 1'b0, 1'b0);
        add_setting(65535, (1 << RANGE_W) - 1, 0);
        add_entry(0, 1'b0, 1'b0);
        add_entry(1, 1'b0, 1'b0);
        add_entry(511, 1'b0, 1'b0);
        // total just below and exactly at the minimum
        add_setting(12500, 511, 2);
        add_entry(5, 1'b0, 1'b0);
        add_entry(511, 1'b0, 1'b0);
        add_setting(12500, 512, 1);
        add_entry(0, 1'b0, 1'b0);
        add_entry(511, 1'b0, 1'b0);
        // spacing just short of saturation
        add_setting(1, 2684, 2);
        add_entry(100, 1'b0, 1'b0);
        add_entry(511, 1'b0, 1'b0);
        add_setting(65535, 0, 2);
        add_entry(3, 1'b0, 1'b0);

        remaining = ENTRY_COUNT - 22;

        // long receiver hold-off while the sender keeps offering
        add_random_setting();
        add_random_entries(120, 1'b1, 10);
        remaining -= 120;

        // one mid-stream pause until the pipe drains
        add_random_setting();
        add_random_entries(40, 1'b0, -1);
        add_settle();
        add_random_entries(40, 1'b0, -1);
        remaining -= 80;

        while (remaining > TAIL_COUNT) begin
            chunk = $urandom_range(40, 90);
            if (chunk > remaining - TAIL_COUNT)
                chunk = remaining - TAIL_COUNT;
            add_random_setting();
            add_random_entries(chunk, 1'b0, -1);
            remaining -= chunk;
        end
        add_random_setting();
        add_random_entries(remaining, 1'b1, -1);

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        while (pending.size() != 0 || s_valid || cfg_valid || spacing_expect.size() != 0)
            @(posedge aclk);
        repeat (10) @(posedge aclk);

        $display("Checked %0d spacing lookups over %0d register settings", results_seen,
                 settings_used);
        $display("(%0d zero spacings, %0d saturated), %0d mismatches", zero_seen, sat_seen,
                 errors);
        if (errors == 0)
            $display("sample_interval_table_generator verification clean");
        else
            $display("sample_interval_table_generator verification failed");
        $finish;
    end

endmodule

// File: sample_interval_table_generator.f
+incdir+hw/rtl
hw/rtl/sitg_pkg.sv
hw/rtl/sitg_div.sv
hw/rtl/sitg_front.sv
hw/rtl/sitg_queue.sv
hw/rtl/sitg_back.sv
hw/rtl/sample_interval_table_generator.sv
test/sample_interval_table_generator_test.sv
